// ----- rtl/core/sdae_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the signed decimal ASCII field encoder.
// Depends on nothing; every module of the block imports it.
package sdae_pkg;

    // Magnitude after saturation fits in 37 bits (99999999999 < 2^37).
    localparam int MagBits = 37;
    // Decimal digits of the saturated magnitude and of the rounded value.
    localparam int MagDigits = 11;
    localparam int RndDigits = 12;
    // Binary-to-BCD conversion: bits taken per cycle and number of cycles.
    localparam int ConvBits  = 6;
    localparam int ConvSteps = 7;
    localparam int ConvWidth = ConvBits * ConvSteps;

    localparam logic [MagBits-1:0] MagLimit = 37'd99999999999;
    localparam logic [4:0] FieldBytesReset = 5'd8;

    // ASCII codes used in the field.
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChCr    = 8'h0D;

    // One converted and rounded value, as it waits for the byte emitter.
    // lead is the position of the leading integer digit (6 to 11).
    typedef struct packed {
        logic                          neg;
        logic                          fend;
        logic [3:0]                    lead;
        logic [RndDigits-1:0][3:0]     digits;
    } entry_t;

endpackage

// ----- rtl/core/sdae_front.sv -----
`timescale 1ns / 1ps
// Front end: takes input items, saturates the magnitude, converts it to
// BCD six bits per step and rounds it. Depends on sdae_pkg.
module sdae_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      field_bytes,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [39:0]     s_tdata,
    input  logic            s_tlast,
    output logic            q_valid,
    input  logic            q_ready,
    output sdae_pkg::entry_t q_data
);
    import sdae_pkg::*;

    // Input holding stage.
    logic                   in_valid_reg, in_valid_next;
    logic                   in_neg_reg;
    logic                   in_fend_reg;
    logic [MagBits-1:0]     in_mag_reg;

    // Converter state.
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [2:0]             step_reg, step_next;
    logic [ConvWidth-1:0]   bin_reg, bin_next;
    logic [MagDigits*4-1:0] bcd_reg, bcd_next;
    logic                   cv_neg_reg;
    logic                   cv_fend_reg;

    logic                   conv_free;
    logic                   load;
    logic                   accept;
    logic [37:0]            raw;
    logic [37:0]            raw_neg;
    logic [37:0]            mag_full;
    logic [MagBits-1:0]     mag_sat;

    // Rounding signals.
    logic [MagDigits-1:0][3:0] dig;
    logic [1:0]             adj;
    logic signed [6:0]      p_s;
    logic                   rnd_on;
    logic [3:0]             p;
    logic                   rnd_up;
    logic                   carry;
    logic [3:0]             d;
    logic [RndDigits-1:0][3:0] rdig;
    logic [3:0]             lead;

    // Six double-dabble bit steps on the BCD register.
    function automatic logic [MagDigits*4-1:0] dabble(
        input logic [MagDigits*4-1:0] bcd_in,
        input logic [ConvBits-1:0]    bits
    );
        logic [MagDigits*4-1:0] acc;
        acc = bcd_in;
        for (int b = ConvBits - 1; b >= 0; b--) begin
            for (int k = 0; k < MagDigits; k++) begin
                if (acc[k*4 +: 4] >= 4'd5) begin
                    acc[k*4 +: 4] = acc[k*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[MagDigits*4-2:0], bits[b]};
        end
        return acc;
    endfunction

    // Sign and saturated magnitude of the incoming item.
    always_comb
    begin
        raw      = s_tdata[37:0];
        raw_neg  = ~raw + 38'd1;
        mag_full = raw[37] ? raw_neg : raw;
        mag_sat  = (mag_full > {1'b0, MagLimit}) ? MagLimit : mag_full[MagBits-1:0];
    end

    assign conv_free = !busy_reg && (!done_reg || q_ready);
    assign load      = in_valid_reg && conv_free;
    assign s_tready  = !in_valid_reg || load;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    // Converter control: load, seven steps, then hold until the queue takes it.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (load) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = 3'd0;
            bin_next  = ConvWidth'(in_mag_reg);
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next  = dabble(bcd_reg, bin_reg[ConvWidth-1 -: ConvBits]);
            bin_next  = {bin_reg[ConvWidth-ConvBits-1:0], {ConvBits{1'b0}}};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'(ConvSteps - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && q_ready) begin
            done_next = 1'b0;
        end
    end

    // Kept digit count and half-up rounding on the decimal digits.
    always_comb
    begin
        dig = bcd_reg;
        if (dig[10] != 4'd0 || dig[9] != 4'd0) begin
            adj = 2'd3;
        end else if (dig[8] != 4'd0) begin
            adj = 2'd2;
        end else if (dig[7] != 4'd0) begin
            adj = 2'd1;
        end else begin
            adj = 2'd0;
        end
        p_s    = 7'sd9 - $signed({2'b00, field_bytes}) + $signed({5'b00000, adj});
        rnd_on = (p_s > 7'sd0);
        p      = rnd_on ? p_s[3:0] : 4'd0;
        rnd_up = rnd_on && (dig[p - 4'd1] >= 4'd5);
        carry  = rnd_up;
        for (int i = 0; i < RndDigits; i++) begin
            d = (i < MagDigits) ? dig[i] : 4'd0;
            if (rnd_on && (4'(i) < p)) begin
                rdig[i] = 4'd0;
            end else if (carry) begin
                rdig[i] = (d == 4'd9) ? 4'd0 : d + 4'd1;
                carry   = (d == 4'd9);
            end else begin
                rdig[i] = d;
            end
        end
        lead = 4'd6;
        for (int i = 7; i < RndDigits; i++) begin
            if (rdig[i] != 4'd0) begin
                lead = 4'(i);
            end
        end
    end

    assign q_valid       = done_reg;
    assign q_data.neg    = cv_neg_reg;
    assign q_data.fend   = cv_fend_reg;
    assign q_data.lead   = lead;
    assign q_data.digits = rdig;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            step_reg     <= 3'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            step_reg     <= step_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_neg_reg  <= raw[37];
            in_fend_reg <= s_tlast;
            in_mag_reg  <= mag_sat;
        end
        if (load) begin
            cv_neg_reg  <= in_neg_reg;
            cv_fend_reg <= in_fend_reg;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ----- rtl/core/sdae_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of rounded values between the front end and the byte
// emitter. Depends on sdae_pkg.
module sdae_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  sdae_pkg::entry_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output sdae_pkg::entry_t pop_data
);
    import sdae_pkg::*;

    entry_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_data   = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/sdae_back.sv -----
`timescale 1ns / 1ps
// Back end: walks one queued value byte by byte into a registered output
// stage. Depends on sdae_pkg.
module sdae_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       field_bytes,
    input  logic             q_valid,
    output logic             q_ready,
    input  sdae_pkg::entry_t q_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import sdae_pkg::*;

    logic [4:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    logic       load_out;
    logic [4:0] last_idx;
    logic       is_last;
    logic [5:0] ti;
    logic [5:0] ndig;
    logic [5:0] pos6;
    logic [7:0] text_ch;
    logic [7:0] byte_ch;

    assign last_idx = q_data.fend ? field_bytes : field_bytes - 5'd1;
    assign is_last  = (idx_reg == last_idx);
    assign load_out = q_valid && (!valid_reg || m_tready);
    assign q_ready  = load_out && is_last;

    // Text character at position idx-1: integer digits, dot, six decimals, stars.
    always_comb
    begin
        ti      = {1'b0, idx_reg} - 6'd1;
        ndig    = {2'b00, q_data.lead} - 6'd5;
        pos6    = 6'd0;
        text_ch = ChStar;
        if (ti < ndig) begin
            pos6    = {2'b00, q_data.lead} - ti;
            text_ch = ChZero | {4'd0, q_data.digits[pos6[3:0]]};
        end else if (ti == ndig) begin
            text_ch = ChDot;
        end else if (ti < ndig + 6'd7) begin
            pos6    = {2'b00, q_data.lead} + 6'd1 - ti;
            text_ch = ChZero | {4'd0, q_data.digits[pos6[3:0]]};
        end
    end

    // Sign byte, field text, then the frame terminator.
    always_comb
    begin
        if (idx_reg == 5'd0) begin
            byte_ch = q_data.neg ? ChMinus : ChPlus;
        end else if (idx_reg < field_bytes) begin
            byte_ch = text_ch;
        end else begin
            byte_ch = ChCr;
        end
    end

    // Byte counter and output valid.
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load_out) begin
            valid_next = 1'b1;
            idx_next   = is_last ? 5'd0 : idx_reg + 5'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 5'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            data_reg <= byte_ch;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- rtl/core/signed_decimal_ascii_field_encoder.sv -----
`timescale 1ns / 1ps
// Top level of the signed decimal ASCII field encoder: configuration
// register, front end, queue and byte emitter. Depends on sdae_pkg.
//
// Usage:
//   Slave channel (s_*): one item per value; s_tdata carries the signed
//   value in millionths, s_tlast marks the last value of a frame.
//   Master channel (m_*): one item per ASCII byte; m_tlast is set on the
//   final byte that an input item causes (the CR byte if the frame ends).
//   cfg_we/cfg_wdata write the field size in bytes (sign included); write
//   it only while the block is idle. It reads 8 after reset.
//   Each value gives field_bytes bytes, plus a CR byte at the frame end.
// Path: an accepted item passes the input holding stage, the converter,
//   the queue and the registered output stage on its way to m_tdata.
// Throughput: the binary-to-BCD converter takes six bits per cycle and
//   starts a new item only once the last one is done and taken by the queue.
//   The emitter gives one byte per cycle while a value waits and m_tready is high.
// Stall: the output stage holds its byte while m_tready is low; a two-entry
//   queue and an input holding stage keep taking items until they fill.
// Reset: rst_n clears all valid flags and counters; no result is pending.
module signed_decimal_ascii_field_encoder #(
    parameter int MAX_FIELD_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // field_bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,        // [37:0] value_micro, [39:38] zero
    input  logic        s_tlast,        // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,        // [7:0] out_byte
    output logic        m_tlast         // last_byte
);
    import sdae_pkg::*;

    localparam int MaxS = (MAX_FIELD_BYTES > 31) ? 31 : MAX_FIELD_BYTES;

    logic [4:0] field_bytes_reg, field_bytes_next;
    logic [4:0] fb_lo;
    logic [4:0] fb_eff;

    logic       f_valid;
    logic       f_ready;
    entry_t     f_data;
    logic       b_valid;
    logic       b_ready;
    entry_t     b_data;

    // Field size register.
    assign field_bytes_next = cfg_we ? cfg_wdata : field_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            field_bytes_reg <= FieldBytesReset;
        end else begin
            field_bytes_reg <= field_bytes_next;
        end
    end

    // Clamp the field size to the supported range.
    always_comb
    begin
        fb_lo  = (field_bytes_reg < 5'd2) ? 5'd2 : field_bytes_reg;
        fb_eff = (fb_lo > 5'(MaxS)) ? 5'(MaxS) : fb_lo;
    end

    sdae_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_bytes (fb_eff),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_valid     (f_valid),
        .q_ready     (f_ready),
        .q_data      (f_data)
    );

    sdae_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    sdae_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_bytes (fb_eff),
        .q_valid     (b_valid),
        .q_ready     (b_ready),
        .q_data      (b_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- sim/sdae_field_checker.sv -----
`timescale 1ns / 1ps
// Stream checker for the signed decimal ASCII field encoder: tracks the field
// size register, predicts the ASCII bytes of every accepted value and compares
// them with the output stream. Depends on sdae_pkg for the ASCII codes, MagLimit and FieldBytesReset.
module sdae_field_checker #(
    parameter int MAX_FIELD_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          bytes_pending
);
    import sdae_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_byte_t;

    localparam longint unsigned Micro = 64'd1000000;

    // Bytes predicted for accepted values and not yet seen at the output.
    ascii_byte_t ascii_q[$];
    logic [4:0]  field_bytes_reg;

    // Predict the field of one value, plus the CR byte at a frame end.
    function automatic void encode_field(input logic [37:0] value, input logic fend);
        longint unsigned mag, unit, rnd, int_part, frac_part, div;
        logic [37:0]     abs_val;
        logic [7:0]      text [0:31];
        logic [7:0]      rev [0:23];
        logic [7:0]      ch;
        logic            neg;
        ascii_byte_t     exp_byte;
        int              size, keep, len, nrev, total, pos, i;
        neg = value[37];
        abs_val = neg ? (~value + 38'd1) : value;
        mag = {26'd0, abs_val};
        if (mag > {27'd0, MagLimit})
            mag = {27'd0, MagLimit};
        size = int'(field_bytes_reg);
        if (size < 2)
            size = 2;
        if (size > MAX_FIELD_BYTES)
            size = MAX_FIELD_BYTES;

        // Fewer decimals are kept as the integer part grows.
        keep = size - 3;
        if (mag >= 64'd1000000000)
            keep = size - 6;
        else if (mag >= 64'd100000000)
            keep = size - 5;
        else if (mag >= 64'd10000000)
            keep = size - 4;

        // Round half-up at the last kept digit; negative keep rounds to tens and up.
        if (keep >= 6) begin
            rnd = mag;
        end else begin
            unit = 1;
            for (i = 0; i < 6 - keep; i++)
                unit = unit * 10;
            rnd = (mag / unit) * unit;
            if (((mag / (unit / 10)) % 10) >= 5)
                rnd = rnd + unit;
        end

        // Integer digits, the point and six decimals.
        int_part = rnd / Micro;
        frac_part = rnd % Micro;
        nrev = 0;
        do begin
            rev[nrev] = ChZero + 8'(int_part % 10);
            nrev++;
            int_part = int_part / 10;
        end while (int_part != 0);
        len = 0;
        while (nrev > 0) begin
            nrev--;
            text[len] = rev[nrev];
            len++;
        end
        text[len] = ChDot;
        len++;
        div = 64'd100000;
        for (i = 0; i < 6; i++) begin
            text[len] = ChZero + 8'((frac_part / div) % 10);
            len++;
            div = div / 10;
        end

        // Sign, text cut or padded to size-1 bytes, then CR if the frame ends.
        total = size + (fend ? 1 : 0);
        for (pos = 0; pos < total; pos++) begin
            if (pos == 0)
                ch = neg ? ChMinus : ChPlus;
            else if (pos < size)
                ch = (pos - 1 < len) ? text[pos - 1] : ChStar;
            else
                ch = ChCr;
            exp_byte.ch = ch;
            exp_byte.last = (pos == total - 1);
            ascii_q = {ascii_q, exp_byte};
        end
    endfunction

    // Output bytes are checked before new predictions are queued.
    always @(posedge clk or negedge rst_n)
    begin
        ascii_byte_t want;
        if (!rst_n) begin
            ascii_q.delete();
            field_bytes_reg <= FieldBytesReset;
            fail_count <= 0;
            bytes_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (ascii_q.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = ascii_q.pop_front();
                    if (want.ch !== m_tdata || want.last !== m_tlast) begin
                        $display("%0t: byte mismatch: expected %h last %b, actual %h last %b",
                                 $time, want.ch, want.last, m_tdata, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                encode_field(s_tdata[37:0], s_tlast);
            if (cfg_we)
                field_bytes_reg <= cfg_wdata;
            bytes_pending <= ascii_q.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, stimulus, output back-pressure
// and the verdict. Depends on the encoder RTL and sdae_field_checker.
module testbench;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    int   fail_count;
    int   bytes_pending;
    int   send_idle_pct = 20;
    int   recv_idle_pct = 78;
    logic hold_req = 1'b0;
    logic recv_hold = 1'b0;

    signed_decimal_ascii_field_encoder #(.MAX_FIELD_BYTES(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sdae_field_checker #(.MAX_FIELD_BYTES(16)) field_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output back-pressure: random stalls, plus a long hold when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off, so that the block fills and stalls its input.
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (300) @(posedge clk);
        recv_hold <= 1'b0;
    end

    // Offer one value, idling at random first, and wait until it is taken.
    task automatic send_value(input logic [37:0] value, input logic fend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, value};
        s_tlast <= fend;
        do @(posedge clk); while (!s_tready);
    endtask

    // Wait until every predicted byte has come out.
    task automatic drain_output();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_field_bytes(input logic [4:0] size);
        drain_output();
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random value: full 38-bit noise, in-range decimals, decade-limited
    // magnitudes, values near the decimal-count thresholds and the limit, rounding ties.
    function automatic logic [37:0] pick_value();
        longint unsigned mag, scale, wide;
        logic [37:0]     value;
        int              kind, i;
        kind = $urandom_range(4);
        wide = {$urandom, $urandom};
        scale = 1;
        case (kind)
            0: mag = wide;
            1: mag = wide % 64'd100000000000;
            2: begin
                for (i = $urandom_range(11); i > 0; i--)
                    scale = scale * 10;
                mag = wide % scale;
            end
            3: begin
                case ($urandom_range(4))
                    0: mag = 64'd10000000;
                    1: mag = 64'd100000000;
                    2: mag = 64'd1000000000;
                    3: mag = 64'd99999999999;
                    default: mag = 64'd1000000;
                endcase
                mag = mag + $urandom_range(2000) - 1000;
            end
            default: begin
                for (i = $urandom_range(10, 1); i > 0; i--)
                    scale = scale * 10;
                mag = $urandom_range(9999) * scale + 5 * (scale / 10)
                      - $urandom_range(1);
            end
        endcase
        value = mag[37:0];
        if (kind != 0 && $urandom_range(1))
            value = ~value + 38'd1;
        return value;
    endfunction

    initial
    begin
        longint       corner_values[22];
        logic [4:0]   size_plan[8];
        int           phase, n;

        corner_values = '{
            0, 1, -1, 4, -4, 5, -5, 9999995, -9999994, 10000000, 99999999,
            100000000, 999999999, 1000000000, 99999999999, -99999999999,
            100000000000, 137438953471, -137438953472, 123456789, -45, 999999
        };
        size_plan = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd5};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed values at the reset field size of 8 bytes.
        foreach (corner_values[i])
            send_value(corner_values[i][37:0], (i % 3 == 2) || (i == 21));

        // Random phases, each at its own field size, in three idling patterns.
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 7)
                size_plan[phase] = 5'($urandom_range(15, 3));
            write_field_bytes(size_plan[phase]);
            if (phase < 3) begin
                send_idle_pct = 20;
                recv_idle_pct = 78;
            end else if (phase < 6) begin
                send_idle_pct = 78;
                recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 6)
                hold_req = 1'b1;
            for (n = 0; n < 25; n++)
                send_value(pick_value(), $urandom_range(3) == 0);
        end

        drain_output();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && bytes_pending == 0)
            $display("PASS signed_decimal_ascii_field_encoder");
        else
            $display("FAIL signed_decimal_ascii_field_encoder");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("FAIL signed_decimal_ascii_field_encoder");
        $finish;
    end

endmodule

// ----- signed_decimal_ascii_field_encoder.f -----
rtl/core/sdae_pkg.sv
rtl/core/sdae_front.sv
rtl/core/sdae_queue.sv
rtl/core/sdae_back.sv
rtl/core/signed_decimal_ascii_field_encoder.sv
sim/sdae_field_checker.sv
sim/testbench.sv
